// ----- rtl/atan2_polynomial_approx_macros.svh -----
// Assertion macros used by the checker of this block.
`ifndef ATAN2_POLYNOMIAL_APPROX_MACROS_SVH
`define ATAN2_POLYNOMIAL_APPROX_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ----- rtl/atan2pa_pkg.sv -----
package atan2pa_pkg;

  localparam int unsigned INPUT_WIDTH     = 16;
  localparam int unsigned ANGLE_FRAC_BITS = 13;
  localparam int unsigned ANGLE_WIDTH     = ANGLE_FRAC_BITS + 3;

  // Q15 quotient of the smaller magnitude over the larger; 2^15 is reachable.
  localparam int unsigned Q_FRAC     = 15;
  localparam int unsigned QUO_WIDTH  = Q_FRAC + 1;

  localparam int unsigned COEF_LIN_WIDTH = 15;
  localparam int unsigned COEF_CUB_WIDTH = 13;
  localparam logic [COEF_LIN_WIDTH-1:0] COEF_LIN = 15'd31863;
  localparam logic [COEF_CUB_WIDTH-1:0] COEF_CUB = 13'd6290;

  localparam int unsigned SQ_PROD_WIDTH  = 2 * QUO_WIDTH;
  localparam int unsigned CUB_PROD_WIDTH = COEF_CUB_WIDTH + QUO_WIDTH;
  localparam int unsigned CUB_TERM_WIDTH = CUB_PROD_WIDTH - Q_FRAC;
  localparam int unsigned T_WIDTH        = COEF_LIN_WIDTH;
  localparam int unsigned AM_PROD_WIDTH  = T_WIDTH + QUO_WIDTH;
  localparam int unsigned AM_SHIFT       = 2 * Q_FRAC - ANGLE_FRAC_BITS;
  localparam int unsigned AM_WIDTH       = ANGLE_FRAC_BITS + 1;

  typedef logic signed [INPUT_WIDTH-1:0] coord_t;
  typedef logic        [INPUT_WIDTH-1:0] mag_t;
  typedef logic        [QUO_WIDTH-1:0]   quo_t;
  typedef logic        [T_WIDTH-1:0]     poly_t;
  typedef logic        [AM_WIDTH-1:0]    am_t;
  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;

  // Pi in Q2.62, rounded to the output precision at elaboration.
  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
  localparam logic [63:0] PI_RND =
    (PI_Q62 + (64'd1 << (61 - ANGLE_FRAC_BITS))) >> (62 - ANGLE_FRAC_BITS);
  localparam logic [63:0] HALF_PI_RND =
    (PI_Q62 + (64'd1 << (62 - ANGLE_FRAC_BITS))) >> (63 - ANGLE_FRAC_BITS);
  localparam angle_t PI_Q      = angle_t'(PI_RND[ANGLE_WIDTH-1:0]);
  localparam angle_t HALF_PI_Q = angle_t'(HALF_PI_RND[ANGLE_WIDTH-1:0]);

  // Quadrant information that rides along with each word.
  typedef struct packed {
    logic xzero;
    logic yzero;
    logic xneg;
    logic yneg;
    logic xbig;
  } flags_t;

endpackage

// ----- rtl/atan2pa_in_if.sv -----
interface atan2pa_in_if;
  import atan2pa_pkg::*;

  logic   valid;
  logic   ready;
  coord_t x_coord;
  coord_t y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

// ----- rtl/atan2pa_out_if.sv -----
interface atan2pa_out_if;
  import atan2pa_pkg::*;

  logic   valid;
  logic   ready;
  angle_t angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

// ----- rtl/atan2pa_prep.sv -----
module atan2pa_prep (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  atan2pa_pkg::coord_t x_coord_i,
  input  atan2pa_pkg::coord_t y_coord_i,
  output logic                valid_o,
  output atan2pa_pkg::mag_t   num_o,
  output atan2pa_pkg::mag_t   den_o,
  output atan2pa_pkg::flags_t flags_o
);
  import atan2pa_pkg::*;

  logic   xneg, yneg;
  mag_t   xm, ym;
  logic   xbig;
  logic   valid_q;
  mag_t   num_q, den_q;
  flags_t flags_q, flags_d;

  // The most negative input negates to itself, which read unsigned is exact.
  assign xneg = x_coord_i[INPUT_WIDTH-1];
  assign yneg = y_coord_i[INPUT_WIDTH-1];
  assign xm   = xneg ? mag_t'(~x_coord_i + 1'b1) : mag_t'(x_coord_i);
  assign ym   = yneg ? mag_t'(~y_coord_i + 1'b1) : mag_t'(y_coord_i);
  assign xbig = xm > ym;

  always_comb begin
    flags_d.xzero = (xm == '0);
    flags_d.yzero = (ym == '0);
    flags_d.xneg  = xneg;
    flags_d.yneg  = yneg;
    flags_d.xbig  = xbig;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q   <= xbig ? ym : xm;
      den_q   <= xbig ? xm : ym;
      flags_q <= flags_d;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign flags_o = flags_q;
endmodule

// ----- rtl/atan2pa_div.sv -----
module atan2pa_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  atan2pa_pkg::mag_t   num_i,
  input  atan2pa_pkg::mag_t   den_i,
  input  atan2pa_pkg::flags_t flags_i,
  output logic                valid_o,
  output atan2pa_pkg::quo_t   quo_o,
  output atan2pa_pkg::flags_t flags_o
);
  import atan2pa_pkg::*;

  localparam int unsigned NSTAGE = QUO_WIDTH;

  // Restoring division, one quotient bit per stage, MSB first.
  // The numerator never exceeds the denominator, so the first stage
  // compares without a shift and every remainder stays below den.
  logic   [NSTAGE-1:0] valid_q;
  quo_t                quo_q   [NSTAGE];
  flags_t              flags_q [NSTAGE];
  mag_t                rem_q   [NSTAGE-1];
  mag_t                den_q   [NSTAGE-1];

  for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
    logic [INPUT_WIDTH:0] trial;
    logic [INPUT_WIDTH:0] diff;
    logic                 ge;
    mag_t                 den_in;
    quo_t                 quo_in;
    flags_t               flags_in;
    logic                 valid_in;

    if (k == 0) begin : g_first
      assign trial    = {1'b0, num_i};
      assign den_in   = den_i;
      assign quo_in   = '0;
      assign flags_in = flags_i;
      assign valid_in = valid_i;
    end else begin : g_next
      assign trial    = {rem_q[k-1], 1'b0};
      assign den_in   = den_q[k-1];
      assign quo_in   = quo_q[k-1];
      assign flags_in = flags_q[k-1];
      assign valid_in = valid_q[k-1];
    end

    assign ge   = trial >= {1'b0, den_in};
    assign diff = trial - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k]   <= {quo_in[QUO_WIDTH-2:0], ge};
        flags_q[k] <= flags_in;
      end
    end

    if (k < NSTAGE - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? diff[INPUT_WIDTH-1:0] : trial[INPUT_WIDTH-1:0];
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign valid_o = valid_q[NSTAGE-1];
  assign quo_o   = quo_q[NSTAGE-1];
  assign flags_o = flags_q[NSTAGE-1];
endmodule

// ----- rtl/atan2pa_poly.sv -----
module atan2pa_poly (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  atan2pa_pkg::quo_t   az_i,
  input  atan2pa_pkg::flags_t flags_i,
  output logic                valid_o,
  output atan2pa_pkg::am_t    am_o,
  output atan2pa_pkg::flags_t flags_o
);
  import atan2pa_pkg::*;

  logic [SQ_PROD_WIDTH-1:0]  sq_prod;
  logic [CUB_PROD_WIDTH-1:0] cub_prod;
  logic [CUB_TERM_WIDTH-1:0] cub_term;
  logic [AM_PROD_WIDTH-1:0]  am_prod;

  logic [2:0] valid_q;
  quo_t       z2_q;
  quo_t       az1_q, az2_q;
  poly_t      t_q;
  am_t        am_q;
  flags_t     flags1_q, flags2_q, flags3_q;

  // Stage 1: z^2 in Q15.
  assign sq_prod  = SQ_PROD_WIDTH'(az_i) * SQ_PROD_WIDTH'(az_i);
  // Stage 2: t = N1 - N2*z^2, N2 taken by magnitude.
  assign cub_prod = CUB_PROD_WIDTH'(COEF_CUB) * CUB_PROD_WIDTH'(z2_q);
  assign cub_term = cub_prod[Q_FRAC +: CUB_TERM_WIDTH];
  // Stage 3: t*z scaled to the output fraction.
  assign am_prod  = AM_PROD_WIDTH'(t_q) * AM_PROD_WIDTH'(az2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z2_q     <= sq_prod[Q_FRAC +: QUO_WIDTH];
      az1_q    <= az_i;
      flags1_q <= flags_i;
      t_q      <= COEF_LIN - T_WIDTH'(cub_term);
      az2_q    <= az1_q;
      flags2_q <= flags1_q;
      am_q     <= am_prod[AM_SHIFT +: AM_WIDTH];
      flags3_q <= flags2_q;
    end
  end

  assign valid_o = valid_q[2];
  assign am_o    = am_q;
  assign flags_o = flags3_q;
endmodule

// ----- rtl/atan2_polynomial_approx.sv -----
// Channel  Dir  Payload                          Role
// in_i     in   x_coord, y_coord (signed 16)     coordinate pair
// out_o    out  angle (signed Q2.13 radians)     atan2(y, x)
//
// One word enters per cycle while no result word waits unread. Each word passes
// through one input stage, the 16-stage restoring divider, one quotient bit per
// stage, three multiply stages and the output stage.
// Reset clears only the valid bits of the stages.
// The whole pipeline advances together: when a result word waits unread,
// every stage holds and in_i.ready is low until that word is taken.
module atan2_polynomial_approx (
  input  logic  clk_i,
  input  logic  rst_ni,
  atan2pa_in_if.sink    in_i,
  atan2pa_out_if.source out_o
);
  import atan2pa_pkg::*;

  logic   en;
  logic   prep_valid, div_valid, poly_valid;
  mag_t   num, den;
  quo_t   quo;
  am_t    am;
  flags_t prep_flags, div_flags, poly_flags;

  logic   out_valid_q;
  angle_t angle_q, angle_d;
  angle_t am_ext, term, offset;
  logic   negate;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  atan2pa_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_i.valid),
    .x_coord_i (in_i.x_coord),
    .y_coord_i (in_i.y_coord),
    .valid_o   (prep_valid),
    .num_o     (num),
    .den_o     (den),
    .flags_o   (prep_flags)
  );

  atan2pa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prep_valid),
    .num_i   (num),
    .den_i   (den),
    .flags_i (prep_flags),
    .valid_o (div_valid),
    .quo_o   (quo),
    .flags_o (div_flags)
  );

  atan2pa_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .az_i    (quo),
    .flags_i (div_flags),
    .valid_o (poly_valid),
    .am_o    (am),
    .flags_o (poly_flags)
  );

  // Quadrant fold. The atan term carries sign(x) xor sign(y); the steep
  // octants subtract it from the +-pi/2 offset.
  assign am_ext = angle_t'(am);

  always_comb begin
    if (poly_flags.xbig) begin
      negate = poly_flags.xneg ^ poly_flags.yneg;
      if (!poly_flags.xneg) begin
        offset = '0;
      end else if (!poly_flags.yneg) begin
        offset = PI_Q;
      end else begin
        offset = -PI_Q;
      end
    end else begin
      negate = !(poly_flags.xneg ^ poly_flags.yneg);
      offset = poly_flags.yneg ? -HALF_PI_Q : HALF_PI_Q;
    end
    term = negate ? -am_ext : am_ext;

    if (poly_flags.xzero) begin
      if (poly_flags.yzero) begin
        angle_d = '0;
      end else begin
        angle_d = poly_flags.yneg ? -HALF_PI_Q : HALF_PI_Q;
      end
    end else begin
      angle_d = offset + term;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= poly_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      angle_q <= angle_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.angle = angle_q;
endmodule

// ----- rtl/atan2pa_checker.sv -----
`include "atan2_polynomial_approx_macros.svh"

module atan2pa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input atan2pa_pkg::angle_t angle_i
);
  import atan2pa_pkg::*;

  // A delivered angle never leaves the closed interval [-pi, pi].
  `ASSERT_IMPL(a_angle_range, clk_i, rst_ni, out_valid_i, (angle_i <= PI_Q) && (angle_i >= -PI_Q))
  // A waiting result word freezes the pipeline, so no input is taken.
  `ASSERT_IMPL(a_stall_blocks_input, clk_i, rst_ni, out_valid_i && !out_ready_i, !in_ready_i)
  // With the output register empty the pipeline always moves.
  `ASSERT_IMPL(a_empty_takes_input, clk_i, rst_ni, !out_valid_i, in_ready_i)
  `ASSERT_NEXT(a_valid_held, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `ASSERT_NEXT(a_angle_held, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(angle_i))

endmodule

bind atan2_polynomial_approx atan2pa_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .angle_i     (out_o.angle)
);
